>>> hdl/qmsm_pkg.sv
// Package: constants, status codes and state type of the query mask subset matcher.
`default_nettype none
package qmsm_pkg;
  localparam int MaxArchetypes = 64;
  localparam int MaxQueries    = 16;
  localparam int MaskBits      = 64;
  localparam int AIdxW = $clog2(MaxArchetypes);
  localparam int QIdxW = $clog2(MaxQueries);
  localparam int ACntW = AIdxW + 1;
  localparam int QCntW = QIdxW + 1;

  typedef enum logic [1:0] {
    REQ_ADD_ARCH  = 2'd0,
    REQ_ADD_QUERY = 2'd1,
    REQ_LIST      = 2'd2,
    REQ_NONE      = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_EXISTS = 3'd1,
    ST_QFULL  = 3'd2,
    ST_BADQ   = 3'd3,
    ST_AFULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_QSCAN, S_LREAD, S_ASCAN, S_EMIT
  } fsm_t;
endpackage
`default_nettype wire

>>> hdl/qmsm_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface qmsm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] mask_value;
  logic [3:0]  query_select;
  modport source (output valid, req_type, mask_value, query_select, input ready);
  modport sink   (input valid, req_type, mask_value, query_select, output ready);
endinterface

interface qmsm_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] query_idx;
  logic [5:0] archetype_index;
  logic       has_match;
  logic       last;
  modport source (output valid, status, query_idx, archetype_index, has_match, last,
                  input ready);
  modport sink   (input valid, status, query_idx, archetype_index, has_match, last,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/query_mask_subset_matcher_unit.sv
// Top level: archetype and query mask tables with a sequential subset-match scan.
`default_nettype none
// One request is handled at a time. Adding an archetype, the archetype-full
// answer and the bad-index answer are given straight from idle, and the
// input is free again once the result is taken. Registering a query
// walks the stored queries one per cycle through the query memory's
// single read port (the query-full answer comes only after this whole
// walk), then, if the mask is new, walks every stored archetype one per
// cycle through the archetype memory, pausing on each match until the
// result transfer can go ahead. Each match after the first makes the scan
// read that entry again after sending the pending result. A listing
// request costs one query read plus the archetype walk. Both memories
// have a registered read; data from unwritten entries is never used, so
// no clearing pass is needed.
module query_mask_subset_matcher_unit
  import qmsm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  qmsm_req_if.sink   in_ch,
  qmsm_res_if.source out_ch
);
  logic [MaskBits-1:0] arch_mem [MaxArchetypes];
  logic [MaskBits-1:0] query_mem [MaxQueries];
  logic [MaskBits-1:0] arch_rd_r, query_rd_r;

  fsm_t state_r, state_nxt;
  logic [ACntW-1:0] arch_tot_r, arch_tot_nxt;
  logic [QCntW-1:0] query_tot_r, query_tot_nxt;
  logic [ACntW-1:0] aptr_r, aptr_nxt;       // address being read
  logic [QCntW-1:0] qptr_r, qptr_nxt;
  logic [MaskBits-1:0] qmask_r, qmask_nxt;
  logic [QIdxW-1:0] qsel_r, qsel_nxt;
  logic             found_r, found_nxt;     // any match found yet

  // Output register
  logic       ov_r, ov_nxt;
  status_t    ost_r, ost_nxt;
  logic [3:0] oq_r, oq_nxt;
  logic [5:0] oa_r, oa_nxt;
  logic       oh_r, oh_nxt, ol_r, ol_nxt;

  logic arch_we, query_we;
  logic [AIdxW-1:0] arch_wa, arch_ra;
  logic [QIdxW-1:0] query_wa, query_ra;
  logic [MaskBits-1:0] in_mask;

  assign in_mask = in_ch.mask_value[MaskBits-1:0];
  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;

  assign out_ch.valid           = ov_r;
  assign out_ch.status          = ost_r;
  assign out_ch.query_idx       = oq_r;
  assign out_ch.archetype_index = oa_r;
  assign out_ch.has_match       = oh_r;
  assign out_ch.last            = ol_r;

  always_ff @(posedge clk) begin
    if (arch_we) arch_mem[arch_wa] <= in_mask;
    arch_rd_r <= arch_mem[arch_ra];
  end

  // The request's input has moved on by the end of the query walk: store the held mask.
  always_ff @(posedge clk) begin
    if (query_we) query_mem[query_wa] <= qmask_r;
    query_rd_r <= query_mem[query_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arch_tot_r  <= '0;
      query_tot_r <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arch_tot_r  <= arch_tot_nxt;
      query_tot_r <= query_tot_nxt;
      ov_r        <= ov_nxt;
    end
    aptr_r  <= aptr_nxt;
    qptr_r  <= qptr_nxt;
    qmask_r <= qmask_nxt;
    qsel_r  <= qsel_nxt;
    found_r <= found_nxt;
    ost_r   <= ost_nxt;
    oq_r    <= oq_nxt;
    oa_r    <= oa_nxt;
    oh_r    <= oh_nxt;
    ol_r    <= ol_nxt;
  end

  // Pointer-1 is the address whose data sits in the read register.
  logic [ACntW-1:0] aprev;
  logic [QCntW-1:0] qprev;
  logic accept, out_free;
  assign aprev    = aptr_r - ACntW'(1);
  assign qprev    = qptr_r - QCntW'(1);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    arch_tot_nxt  = arch_tot_r;
    query_tot_nxt = query_tot_r;
    aptr_nxt      = aptr_r;
    qptr_nxt      = qptr_r;
    qmask_nxt     = qmask_r;
    qsel_nxt      = qsel_r;
    found_nxt     = found_r;
    ov_nxt        = ov_r && !out_ch.ready;
    ost_nxt       = ost_r;
    oq_nxt        = oq_r;
    oa_nxt        = oa_r;
    oh_nxt        = oh_r;
    ol_nxt        = ol_r;
    arch_we       = 1'b0;
    query_we      = 1'b0;
    arch_wa       = arch_tot_r[AIdxW-1:0];
    query_wa      = query_tot_r[QIdxW-1:0];
    arch_ra       = aptr_r[AIdxW-1:0];
    query_ra      = qptr_r[QIdxW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          qmask_nxt = in_mask;
          found_nxt = 1'b0;
          oq_nxt = '0; oa_nxt = '0; oh_nxt = 1'b0; ol_nxt = 1'b1;
          ost_nxt = ST_DONE;
          unique case (req_type_t'(in_ch.req_type))
            REQ_ADD_ARCH: begin
              ov_nxt = 1'b1;
              if (arch_tot_r == ACntW'(MaxArchetypes)) begin
                ost_nxt = ST_AFULL;
              end else begin
                arch_we      = 1'b1;
                oa_nxt       = 6'(arch_tot_r);
                oh_nxt       = 1'b1;
                arch_tot_nxt = arch_tot_r + ACntW'(1);
              end
            end
            REQ_ADD_QUERY: begin
              // launch read of query 0
              query_ra    = '0;
              qptr_nxt    = QCntW'(1);
              state_nxt   = S_QSCAN;
            end
            REQ_LIST: begin
              qsel_nxt = in_ch.query_select[QIdxW-1:0];
              if (QCntW'(in_ch.query_select) >= query_tot_r) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_BADQ;
                oq_nxt  = in_ch.query_select;
              end else begin
                query_ra  = in_ch.query_select[QIdxW-1:0];
                state_nxt = S_LREAD;
              end
            end
            default: ;
          endcase
        end
      end

      S_QSCAN: begin
        if (qprev < query_tot_r && query_rd_r == qmask_r) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_EXISTS;
          oq_nxt    = 4'(qprev);
          state_nxt = S_IDLE;
        end else if (qprev >= query_tot_r) begin
          if (query_tot_r == QCntW'(MaxQueries)) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_QFULL;
            state_nxt = S_IDLE;
          end else begin
            query_we      = 1'b1;
            query_tot_nxt = query_tot_r + QCntW'(1);
            qsel_nxt      = query_tot_r[QIdxW-1:0];
            arch_ra       = '0;
            aptr_nxt      = ACntW'(1);
            state_nxt     = S_ASCAN;
          end
        end else begin
          qptr_nxt = qptr_r + QCntW'(1);
        end
      end

      S_LREAD: begin
        qmask_nxt = query_rd_r;
        arch_ra   = '0;
        aptr_nxt  = ACntW'(1);
        state_nxt = S_ASCAN;
      end

      S_ASCAN: begin
        // arch_rd_r holds entry aprev; re-read that entry while stalled
        if (aprev >= arch_tot_r) begin
          if (out_free) begin
            ov_nxt = 1'b1; ost_nxt = ST_DONE; oq_nxt = 4'(qsel_r);
            ol_nxt = 1'b1; oa_nxt = '0; oh_nxt = 1'b0;
            if (found_r) begin
              ov_nxt = 1'b0; // final match already flagged as last
            end
            state_nxt = S_IDLE;
          end else begin
            arch_ra = aprev[AIdxW-1:0];
          end
        end else if ((arch_rd_r & qmask_r) == qmask_r) begin
          if (out_free) begin
            // look ahead: last when no later entry matches is unknown, so
            // emit and decide last in S_EMIT by scanning on
            found_nxt = 1'b1;
            oa_nxt    = 6'(aprev);
            state_nxt = S_EMIT;
            aptr_nxt  = aptr_r + ACntW'(1);
          end else begin
            arch_ra = aprev[AIdxW-1:0];
          end
        end else begin
          aptr_nxt = aptr_r + ACntW'(1);
        end
      end

      S_EMIT: begin
        // pending match in oa_r; arch_rd_r holds entry aprev. Scan for the
        // next match to know whether the pending one is last.
        if (aprev >= arch_tot_r) begin
          if (out_free) begin
            ov_nxt = 1'b1; ost_nxt = ST_DONE; oq_nxt = 4'(qsel_r);
            oh_nxt = 1'b1; ol_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            arch_ra = aprev[AIdxW-1:0];
          end
        end else if ((arch_rd_r & qmask_r) == qmask_r) begin
          if (out_free) begin
            ov_nxt = 1'b1; ost_nxt = ST_DONE; oq_nxt = 4'(qsel_r);
            oh_nxt = 1'b1; ol_nxt = 1'b0;
            state_nxt = S_ASCAN;
            arch_ra   = aprev[AIdxW-1:0];
          end else begin
            arch_ra = aprev[AIdxW-1:0];
          end
        end else begin
          aptr_nxt = aptr_r + ACntW'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/qmsm_checker.sv
// Checker: port-level properties of the matcher, bound to the top level.
`default_nettype none
module qmsm_checker
  import qmsm_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic [1:0] in_req_type,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] out_status,
  input wire logic out_has_match,
  input wire logic out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_last && !out_has_match)
    else $error("error result not final");
  a_nohit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_match |-> out_last) else $error("no-match not final");
  // An unused request code is dropped on the spot and leaves the input free.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type != REQ_NONE |=> !in_ready)
    else $error("accepted during work");
endmodule

bind query_mask_subset_matcher_unit qmsm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_req_type(in_ch.req_type),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
  .out_has_match(out_ch.has_match), .out_last(out_ch.last)
);
`default_nettype wire

>>> verif/query_mask_subset_matcher_unit_tb.sv
// Testbench: directed table and random requests checked against a mask-table subset predictor.
`default_nettype none
module query_mask_subset_matcher_unit_tb;
  import qmsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t    status;
    logic [3:0] qidx;
    logic [5:0] aidx;
    logic       hit;
    logic       last;
  } match_res_t;

  typedef struct {
    req_type_t   kind;
    logic [63:0] mask;
    logic [3:0]  sel;
    bit          typed;
    match_res_t  res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  qmsm_req_if in_ch ();
  qmsm_res_if out_ch ();

  query_mask_subset_matcher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Predictor state: mirrors the two mask tables and their fill counts.
  logic [63:0] arch_masks [MaxArchetypes];
  int          arch_count;
  logic [63:0] query_tbl [MaxQueries];
  int          query_fill;

  match_res_t  pending_q [$];   // results still owed by the block
  match_res_t  predicted [$];   // scratch output of the predictor
  stim_row_t   dir_rows [$];

  int errors, results_seen, hits_seen, items_sent;
  bit hold_off_req;
  bit timed_out;

  // Work out the results of one accepted request and update the tables.
  function automatic void predict_request(req_type_t kind, logic [63:0] mask,
                                          logic [3:0] sel);
    logic [63:0] qm;
    int          qi;
    int          found;
    predicted.delete();
    found = -1;
    case (kind)
      REQ_ADD_ARCH: begin
        if (arch_count >= MaxArchetypes) begin
          predicted.push_back('{ST_AFULL, 4'd0, 6'd0, 1'b0, 1'b1});
        end else begin
          arch_masks[arch_count] = mask;
          predicted.push_back('{ST_DONE, 4'd0, 6'(arch_count), 1'b1, 1'b1});
          arch_count++;
        end
      end
      REQ_ADD_QUERY, REQ_LIST: begin
        qi = -1;
        if (kind == REQ_ADD_QUERY) begin
          for (int i = 0; i < query_fill; i++)
            if (found < 0 && query_tbl[i] == mask) found = i;
          if (found >= 0) begin
            predicted.push_back('{ST_EXISTS, 4'(found), 6'd0, 1'b0, 1'b1});
          end else if (query_fill >= MaxQueries) begin
            predicted.push_back('{ST_QFULL, 4'd0, 6'd0, 1'b0, 1'b1});
          end else begin
            query_tbl[query_fill] = mask;
            qi = query_fill;
            query_fill++;
          end
        end else if (sel >= query_fill) begin
          predicted.push_back('{ST_BADQ, sel, 6'd0, 1'b0, 1'b1});
        end else begin
          qi = sel;
        end
        if (qi >= 0) begin
          qm = query_tbl[qi];
          for (int a = 0; a < arch_count; a++)
            if ((arch_masks[a] & qm) == qm)
              predicted.push_back('{ST_DONE, 4'(qi), 6'(a), 1'b1, 1'b0});
          if (predicted.size() == 0)
            predicted.push_back('{ST_DONE, 4'(qi), 6'd0, 1'b0, 1'b1});
          else
            predicted[$].last = 1'b1;
        end
      end
      default: ;  // unused request code: nothing comes back
    endcase
  endfunction

  function automatic void add_row(req_type_t kind, logic [63:0] mask, logic [3:0] sel,
                                  bit typed, match_res_t res);
    dir_rows.push_back('{kind, mask, sel, typed, res});
  endfunction

  function automatic match_res_t no_res();
    return '{ST_DONE, 4'd0, 6'd0, 1'b0, 1'b0};
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #20ms;
    timed_out = 1'b1;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, field-by-field check.
  initial begin
    int gap, burst;
    match_res_t got, want;
    out_ch.ready = 1'b0;
    burst = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        // hold off long enough for the request side to back up
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (burst == 0 && $urandom_range(0, 9) == 0) burst = 30;
      if (burst > 0) begin
        gap = 0;
        burst--;
      end else begin
        gap = $urandom_range(0, 13);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got = '{status_t'(out_ch.status), out_ch.query_idx, out_ch.archetype_index,
              out_ch.has_match, out_ch.last};
      results_seen++;
      if (got.hit) hits_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status || got.qidx !== want.qidx ||
            got.aidx !== want.aidx || got.hit !== want.hit || got.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result mismatch, expected %p, got %p", want, got);
        end
      end
    end
  end

  // Request side
  initial begin
    int gap, burst, n_random, r;
    stim_row_t row;
    logic [63:0] m;
    req_type_t kind;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_NONE;
    in_ch.mask_value   = '0;
    in_ch.query_select = '0;
    rst_n              = 1'b0;
    arch_count = 0;
    query_fill = 0;
    burst = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; typed results are checked directly, the rest by the predictor.
    add_row(REQ_LIST, '0, 4'd0, 1, '{ST_BADQ, 4'd0, 6'd0, 1'b0, 1'b1});
    add_row(REQ_ADD_QUERY, 64'h0f0f_0000_0000_00f0, 4'd0, 1,
            '{ST_DONE, 4'd0, 6'd0, 1'b0, 1'b1});     // no archetypes yet: no match
    add_row(REQ_ADD_ARCH, '1, 4'd0, 1, '{ST_DONE, 4'd0, 6'd0, 1'b1, 1'b1});
    add_row(REQ_ADD_ARCH, '0, 4'd0, 1, '{ST_DONE, 4'd0, 6'd1, 1'b1, 1'b1});
    add_row(REQ_ADD_ARCH, 64'h5555_5555_5555_5555, 4'd0, 1,
            '{ST_DONE, 4'd0, 6'd2, 1'b1, 1'b1});
    add_row(REQ_ADD_ARCH, 64'hffff_0000_ffff_0000, 4'd0, 0, no_res());
    add_row(REQ_ADD_QUERY, '0, 4'd0, 0, no_res());   // empty mask matches every archetype
    add_row(REQ_ADD_QUERY, '0, 4'd0, 1, '{ST_EXISTS, 4'd1, 6'd0, 1'b0, 1'b1});
    add_row(REQ_ADD_QUERY, '1, 4'd0, 0, no_res());
    add_row(REQ_ADD_QUERY, 64'h8000_0000_0000_0001, 4'd0, 0, no_res());
    add_row(REQ_ADD_QUERY, 64'h0000_0001_0000_0001, 4'd0, 0, no_res());
    add_row(REQ_ADD_QUERY, 64'haaaa_aaaa_aaaa_aaaa, 4'd0, 0, no_res());
    add_row(REQ_NONE, '1, 4'hf, 0, no_res());        // ignored request code
    add_row(REQ_LIST, '1, 4'd0, 0, no_res());        // mask field unused on listing
    add_row(REQ_LIST, '0, 4'd1, 0, no_res());
    add_row(REQ_ADD_ARCH, 64'h8000_0001_8000_0001, 4'd0, 0, no_res());
    add_row(REQ_LIST, '0, 4'd4, 0, no_res());        // listing sees the newer archetype
    add_row(REQ_LIST, '0, 4'hf, 1, '{ST_BADQ, 4'hf, 6'd0, 1'b0, 1'b1});
    add_row(REQ_LIST, '0, 4'd6, 1, '{ST_BADQ, 4'd6, 6'd0, 1'b0, 1'b1});

    // Random part: mostly archetype adds so the table fills, subset-style queries so
    // that matches are plentiful, and a few stray codes.
    n_random = 111;
    for (int k = 0; k < dir_rows.size() + n_random; k++) begin
      if (k < dir_rows.size()) begin
        row = dir_rows[k];
      end else begin
        r = $urandom_range(0, 99);
        row.typed = 0;
        row.sel   = 4'($urandom_range(0, 15));
        m = {$urandom(), $urandom()};
        if (r < 50) begin
          kind = REQ_ADD_ARCH;
          if ($urandom_range(0, 3) == 0) m = m | {$urandom(), $urandom()};
        end else if (r < 78) begin
          kind = REQ_ADD_QUERY;
          if (query_fill > 0 && $urandom_range(0, 3) == 0)
            m = query_tbl[$urandom_range(0, query_fill - 1)];
          else if (arch_count > 0 && $urandom_range(0, 4) != 0)
            m = arch_masks[$urandom_range(0, arch_count - 1)] & m & {$urandom(), $urandom()};
        end else if (r < 96) begin
          kind = REQ_LIST;
          if (query_fill > 0 && $urandom_range(0, 3) != 0)
            row.sel = 4'($urandom_range(0, query_fill - 1));
        end else begin
          kind = REQ_NONE;
        end
        row.kind = kind;
        row.mask = m;
      end

      // Pressure points: one long result stall, one full drain before sending on.
      if (k == dir_rows.size() + 40) hold_off_req = 1'b1;
      if (k == dir_rows.size() + 85) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_q.size() != 0);
      end

      if (burst == 0 && $urandom_range(0, 9) == 0) burst = 25;
      if (burst > 0) begin
        gap = 0;
        burst--;
      end else begin
        gap = $urandom_range(0, 13);
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid        <= 1'b1;
      in_ch.req_type     <= row.kind;
      in_ch.mask_value   <= row.mask;
      in_ch.query_select <= row.sel;
      do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
      items_sent++;

      // Transfer accepted: advance the predictor, take typed rows as written.
      predict_request(row.kind, row.mask, row.sel);
      if (row.typed) pending_q.push_back(row.res);
      else foreach (predicted[i]) pending_q.push_back(predicted[i]);
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Sent %0d requests, checked %0d results (%0d with a match).",
             items_sent, results_seen, hits_seen);
    $display("Archetype table reached %0d entries, query table %0d entries.",
             arch_count, query_fill);
    if (errors == 0 && pending_q.size() == 0 && !timed_out) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
